FILE: design/vcm_pkg.sv
// shared types, constants and codes for the viewport coordinate mapper
package vcm_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int DIM_BITS        = 13;

  localparam int COORD_W      = 32;
  localparam int FUNC_W       = 3;
  localparam int MODE_W       = 2;
  localparam int SCALE_W      = DIM_BITS + SCALE_FRAC_BITS;
  localparam int PROD_W       = DIM_BITS + SCALE_W;
  localparam int CENTRE_SHIFT = SCALE_FRAC_BITS + 1 - COORD_FRAC_BITS;
  localparam int OFS_W        = PROD_W + 1 - CENTRE_SHIFT;
  localparam int N_W          = OFS_W + 1;
  localparam int MUL_W        = COORD_W + SCALE_W;
  localparam int SUM_W        = MUL_W - SCALE_FRAC_BITS + 2;
  localparam int Q_W          = COORD_W - 1;
  localparam int LOWB         = Q_W - SCALE_FRAC_BITS;
  localparam int CMP_W        = SCALE_W + LOWB;
  localparam int LIM_W        = DIM_BITS + COORD_FRAC_BITS;
  localparam int DIV_STAGES   = Q_W;

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_L2P_POINT  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_P2L_POINT  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_P2L_CLAMP  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_L2P_EXTENT = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_P2L_EXTENT = 3'd4;

  localparam logic [MODE_W-1:0] MODE_STRETCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIT     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_INT_FIT = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_LOGICAL_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOGICAL_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_WIDTH   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_HEIGHT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_MODE     = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] result_x;
    logic signed [COORD_W-1:0] result_y;
    logic                      inside_res;
    logic                      valid_res;
  } result_t;

  typedef struct packed {
    logic                      busy;
    logic                      valid;
    logic [DIM_BITS-1:0]       lw;
    logic [DIM_BITS-1:0]       lh;
    logic [DIM_BITS-1:0]       ow;
    logic [DIM_BITS-1:0]       oh;
    logic [SCALE_W-1:0]        sx;
    logic [SCALE_W-1:0]        sy;
    logic signed [OFS_W-1:0]   ox;
    logic signed [OFS_W-1:0]   oy;
  } cfg_t;

  typedef struct packed {
    logic           neg;
    logic [N_W-1:0] mag;
  } fb_lane_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pre_in;
    fb_lane_t          x;
    fb_lane_t          y;
  } fb_t;

  typedef struct packed {
    logic               neg;
    logic               ovf;
    logic [MUL_W-1:0]   prod;
    logic [SCALE_W-1:0] rem;
    logic [LOWB-1:0]    lo;
  } fc_lane_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pre_in;
    fc_lane_t          x;
    fc_lane_t          y;
  } fc_t;

  typedef struct packed {
    logic                      neg;
    logic                      ovf;
    logic [SCALE_W-1:0]        rem;
    logic [LOWB-1:0]           lo;
    logic [Q_W-1:0]            q;
    logic signed [COORD_W-1:0] mres;
  } ds_lane_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pre_in;
    ds_lane_t          x;
    ds_lane_t          y;
  } ds_t;

endpackage

FILE: design/vcm_cfg.sv
// register file and sequential scale and offset computation
module vcm_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vcm_pkg::PADDR_W-1:0]   paddr,
  input  logic [vcm_pkg::PDATA_W-1:0]   pwdata,
  output logic [vcm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output vcm_pkg::cfg_t                 cfg
);
  import vcm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SEL  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_OFS  = 3'd5;

  localparam int CNT_W = $clog2(SCALE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCALE_W - 1);
  localparam logic [SCALE_W-1:0] ONE = SCALE_W'(1) << SCALE_FRAC_BITS;

  logic [DIM_BITS-1:0]     lw, lh, ow, oh;
  logic [MODE_W-1:0]       mode;
  logic [2:0]              state;
  logic [CNT_W-1:0]        cnt;
  logic [SCALE_W-1:0]      numx, numy, qx, qy;
  logic [DIM_BITS-1:0]     remx, remy;
  logic [SCALE_W-1:0]      sx, sy, sx_next, sy_next;
  logic [PROD_W-1:0]       px, py;
  logic signed [OFS_W-1:0] ox, oy;
  logic                    valid;
  logic                    wr;
  logic [REG_IDX_W-1:0]    idx;
  logic [DIM_BITS:0]       trialx, trialy;
  logic                    gex, gey;
  logic [SCALE_W-1:0]      smin, smax, sint;
  logic                    dims_ok;

  function automatic logic signed [OFS_W-1:0] centre(input logic [DIM_BITS-1:0] dim,
                                                     input logic [PROD_W-1:0] p);
    logic signed [PROD_W:0] d;
    logic [PROD_W:0]        m;
    logic [OFS_W-1:0]       sh;
    d  = $signed({1'b0, PROD_W'(dim) << SCALE_FRAC_BITS}) - $signed({1'b0, p});
    m  = d[PROD_W] ? $unsigned(-d) : $unsigned(d);
    sh = OFS_W'(m >> CENTRE_SHIFT);
    return d[PROD_W] ? -$signed(sh) : $signed(sh);
  endfunction

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw   <= '0;
      lh   <= '0;
      ow   <= '0;
      oh   <= '0;
      mode <= MODE_FIT;
    end else if (wr) begin
      unique case (idx)
        REG_LOGICAL_WIDTH:  lw   <= pwdata[DIM_BITS-1:0];
        REG_LOGICAL_HEIGHT: lh   <= pwdata[DIM_BITS-1:0];
        REG_OUTPUT_WIDTH:   ow   <= pwdata[DIM_BITS-1:0];
        REG_OUTPUT_HEIGHT:  oh   <= pwdata[DIM_BITS-1:0];
        REG_SCALE_MODE:     mode <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LOGICAL_WIDTH:  prdata = PDATA_W'(lw);
      REG_LOGICAL_HEIGHT: prdata = PDATA_W'(lh);
      REG_OUTPUT_WIDTH:   prdata = PDATA_W'(ow);
      REG_OUTPUT_HEIGHT:  prdata = PDATA_W'(oh);
      REG_SCALE_MODE:     prdata = PDATA_W'(mode);
      default:            prdata = '0;
    endcase
  end

  // restoring division, one quotient bit per cycle
  assign trialx = {remx, numx[SCALE_W-1]};
  assign trialy = {remy, numy[SCALE_W-1]};
  assign gex    = trialx >= {1'b0, lw};
  assign gey    = trialy >= {1'b0, lh};

  assign smin    = (qx < qy) ? qx : qy;
  assign smax    = (qx > qy) ? qx : qy;
  assign sint    = (smin >= ONE) ? (smin & ~(ONE - SCALE_W'(1))) : smin;
  assign dims_ok = (lw != '0) && (lh != '0) && (ow != '0) && (oh != '0);

  always_comb begin
    unique case (mode)
      MODE_STRETCH: begin
        sx_next = qx;
        sy_next = qy;
      end
      MODE_FIT: begin
        sx_next = smin;
        sy_next = smin;
      end
      MODE_FILL: begin
        sx_next = smax;
        sy_next = smax;
      end
      MODE_INT_FIT: begin
        sx_next = sint;
        sy_next = sint;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else if (wr) begin
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == CNT_LAST) state <= ST_SEL;
        end
        ST_SEL: begin
          state <= ST_MUL;
          valid <= dims_ok && (sx_next != '0) && (sy_next != '0);
        end
        ST_MUL:  state <= ST_OFS;
        ST_OFS:  state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_LOAD: begin
        numx <= SCALE_W'(ow) << SCALE_FRAC_BITS;
        numy <= SCALE_W'(oh) << SCALE_FRAC_BITS;
        remx <= '0;
        remy <= '0;
        qx   <= '0;
        qy   <= '0;
        cnt  <= '0;
      end
      ST_DIV: begin
        numx <= numx << 1;
        numy <= numy << 1;
        remx <= gex ? DIM_BITS'(trialx - {1'b0, lw}) : trialx[DIM_BITS-1:0];
        remy <= gey ? DIM_BITS'(trialy - {1'b0, lh}) : trialy[DIM_BITS-1:0];
        qx   <= {qx[SCALE_W-2:0], gex};
        qy   <= {qy[SCALE_W-2:0], gey};
        cnt  <= cnt + CNT_W'(1);
      end
      ST_SEL: begin
        sx <= sx_next;
        sy <= sy_next;
      end
      ST_MUL: begin
        px <= PROD_W'(lw) * PROD_W'(sx);
        py <= PROD_W'(lh) * PROD_W'(sy);
      end
      ST_OFS: begin
        ox <= (mode == MODE_STRETCH) ? '0 : centre(ow, px);
        oy <= (mode == MODE_STRETCH) ? '0 : centre(oh, py);
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg.busy  = state != ST_IDLE;
    cfg.valid = valid;
    cfg.lw    = lw;
    cfg.lh    = lh;
    cfg.ow    = ow;
    cfg.oh    = oh;
    cfg.sx    = sx;
    cfg.sy    = sy;
    cfg.ox    = ox;
    cfg.oy    = oy;
  end

endmodule

FILE: design/vcm_front.sv
// front stages: capture, offset and magnitude, multiply, divider setup
module vcm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          v_in,
  input  vcm_pkg::item_t item,
  input  vcm_pkg::cfg_t  cfg,
  output logic          v_out,
  output vcm_pkg::ds_t   ds
);
  import vcm_pkg::*;

  logic  va, vb, vc, vd;
  item_t ia;
  fb_t   fb, fb_next;
  fc_t   fc, fc_next;
  ds_t   dd, dd_next;
  logic  sub;

  function automatic fb_lane_t prep(input logic signed [COORD_W-1:0] c,
                                    input logic signed [OFS_W-1:0] o,
                                    input logic s);
    logic signed [N_W-1:0] n;
    fb_lane_t              r;
    n = s ? $signed({{(N_W-COORD_W){c[COORD_W-1]}}, c}) -
            $signed({{(N_W-OFS_W){o[OFS_W-1]}}, o})
          : $signed({{(N_W-COORD_W){c[COORD_W-1]}}, c});
    r.neg = n[N_W-1];
    r.mag = n[N_W-1] ? $unsigned(-n) : $unsigned(n);
    return r;
  endfunction

  function automatic logic in_range(input logic signed [COORD_W-1:0] c,
                                    input logic [DIM_BITS-1:0] dim);
    return !c[COORD_W-1] &&
           ($unsigned(c) < COORD_W'({dim, {COORD_FRAC_BITS{1'b0}}}));
  endfunction

  function automatic fc_lane_t setup(input fb_lane_t l, input logic [SCALE_W-1:0] s);
    fc_lane_t r;
    r.neg  = l.neg;
    r.prod = MUL_W'(l.mag[COORD_W-1:0]) * MUL_W'(s);
    r.ovf  = CMP_W'(l.mag) >= (CMP_W'(s) << LOWB);
    r.rem  = SCALE_W'(l.mag >> LOWB);
    r.lo   = l.mag[LOWB-1:0];
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] mres(input fc_lane_t l,
                                                     input logic signed [OFS_W-1:0] o,
                                                     input logic add_o);
    logic [MUL_W-SCALE_FRAC_BITS-1:0] t;
    logic signed [SUM_W-1:0]          v;
    t = l.prod[MUL_W-1:SCALE_FRAC_BITS];
    v = l.neg ? -$signed({2'b00, t}) : $signed({2'b00, t});
    if (add_o) v = v + $signed({{(SUM_W-OFS_W){o[OFS_W-1]}}, o});
    if (v > $signed({{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}}))
      return {1'b0, {(COORD_W-1){1'b1}}};
    else if (v < $signed({{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
      return {1'b1, {(COORD_W-1){1'b0}}};
    else
      return v[COORD_W-1:0];
  endfunction

  function automatic ds_lane_t start(input fc_lane_t l,
                                     input logic signed [OFS_W-1:0] o,
                                     input logic add_o);
    ds_lane_t r;
    r.neg  = l.neg;
    r.ovf  = l.ovf;
    r.rem  = l.rem;
    r.lo   = l.lo;
    r.q    = '0;
    r.mres = mres(l, o, add_o);
    return r;
  endfunction

  assign sub = (ia.func == FUNC_P2L_POINT) || (ia.func == FUNC_P2L_CLAMP);

  always_comb begin
    fb_next.func   = ia.func;
    fb_next.pre_in = in_range(ia.coord_x, cfg.ow) && in_range(ia.coord_y, cfg.oh);
    fb_next.x      = prep(ia.coord_x, cfg.ox, sub);
    fb_next.y      = prep(ia.coord_y, cfg.oy, sub);

    fc_next.func   = fb.func;
    fc_next.pre_in = fb.pre_in;
    fc_next.x      = setup(fb.x, cfg.sx);
    fc_next.y      = setup(fb.y, cfg.sy);

    dd_next.func   = fc.func;
    dd_next.pre_in = fc.pre_in;
    dd_next.x      = start(fc.x, cfg.ox, fc.func == FUNC_L2P_POINT);
    dd_next.y      = start(fc.y, cfg.oy, fc.func == FUNC_L2P_POINT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (adv) begin
      va <= v_in;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ia <= item;
      fb <= fb_next;
      fc <= fc_next;
      dd <= dd_next;
    end
  end

  assign v_out = vd;
  assign ds    = dd;

endmodule

FILE: design/vcm_div_step.sv
// one quotient bit of the pipelined divider for both axes
module vcm_div_step (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         v_in,
  input  vcm_pkg::ds_t                 d_in,
  input  logic [vcm_pkg::SCALE_W-1:0]  sx,
  input  logic [vcm_pkg::SCALE_W-1:0]  sy,
  output logic                         v_out,
  output vcm_pkg::ds_t                 d_out
);
  import vcm_pkg::*;

  logic v;
  ds_t  d, d_next;

  function automatic ds_lane_t step(input ds_lane_t l, input logic [SCALE_W-1:0] s);
    logic [SCALE_W:0] trial;
    logic             ge;
    ds_lane_t         r;
    r     = l;
    trial = {l.rem, l.lo[LOWB-1]};
    ge    = trial >= {1'b0, s};
    r.rem = ge ? SCALE_W'(trial - {1'b0, s}) : trial[SCALE_W-1:0];
    r.lo  = l.lo << 1;
    r.q   = {l.q[Q_W-2:0], ge};
    return r;
  endfunction

  always_comb begin
    d_next   = d_in;
    d_next.x = step(d_in.x, sx);
    d_next.y = step(d_in.y, sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) d <= d_next;
  end

  assign v_out = v;
  assign d_out = d;

endmodule

FILE: design/vcm_back.sv
// final stage: sign, clamp, inside test, saturation and result register
module vcm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             v_in,
  input  vcm_pkg::ds_t     d,
  input  vcm_pkg::cfg_t    cfg,
  output logic             v_out,
  output vcm_pkg::result_t res
);
  import vcm_pkg::*;

  logic                      v;
  result_t                   r, r_next;
  logic signed [COORD_W:0]   rvx, rvy, lwq, lhq, cx, cy;
  logic                      in_all;

  function automatic logic signed [COORD_W:0] qval(input ds_lane_t l);
    logic [COORD_W-1:0] m;
    m = l.ovf ? {1'b1, {Q_W{1'b0}}} : {1'b0, l.q};
    return l.neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [COORD_W:0] a);
    if (a > $signed({2'b00, {(COORD_W-1){1'b1}}}))
      return {1'b0, {(COORD_W-1){1'b1}}};
    else
      return a[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W:0] clamp(input logic signed [COORD_W:0] a,
                                                    input logic signed [COORD_W:0] lim);
    if (a[COORD_W]) return '0;
    else if (a > lim) return lim;
    else return a;
  endfunction

  assign rvx = qval(d.x);
  assign rvy = qval(d.y);
  assign lwq = $signed((COORD_W+1)'({cfg.lw, {COORD_FRAC_BITS{1'b0}}}));
  assign lhq = $signed((COORD_W+1)'({cfg.lh, {COORD_FRAC_BITS{1'b0}}}));
  assign cx  = clamp(rvx, lwq);
  assign cy  = clamp(rvy, lhq);
  assign in_all = d.pre_in && !rvx[COORD_W] && !rvy[COORD_W] && (rvx < lwq) && (rvy < lhq);

  always_comb begin
    r_next = '0;
    if (cfg.valid && (d.func <= FUNC_P2L_EXTENT)) begin
      r_next.valid_res = 1'b1;
      unique case (d.func)
        FUNC_L2P_POINT, FUNC_L2P_EXTENT: begin
          r_next.result_x = d.x.mres;
          r_next.result_y = d.y.mres;
        end
        FUNC_P2L_POINT: begin
          r_next.result_x   = sat(rvx);
          r_next.result_y   = sat(rvy);
          r_next.inside_res = in_all;
        end
        FUNC_P2L_CLAMP: begin
          r_next.result_x   = sat(cx);
          r_next.result_y   = sat(cy);
          r_next.inside_res = in_all;
        end
        FUNC_P2L_EXTENT: begin
          r_next.result_x = sat(rvx);
          r_next.result_y = sat(rvy);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) r <= r_next;
  end

  assign v_out = v;
  assign res   = r;

endmodule

FILE: design/viewport_coordinate_mapper_unit.sv
// viewport coordinate mapper top level: config port and 36-stage mapping pipeline
// stages from accepted word to result: 4 front, 31 divider, 1 output
// throughput: one word per cycle while no scale recompute runs; a full stall of the result freezes the whole pipe
// a config write recomputes scales and offsets, item_ready is low while that recompute runs
// reset (synchronous, rst high): dimensions 0, fit mode, pipeline empty, results invalid
module viewport_coordinate_mapper_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  vcm_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output vcm_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vcm_pkg::PADDR_W-1:0]  paddr,
  input  logic [vcm_pkg::PDATA_W-1:0]  pwdata,
  output logic [vcm_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import vcm_pkg::*;

  cfg_t                cfg;
  logic                adv;
  logic [DIV_STAGES:0] dv;
  ds_t                 dd [DIV_STAGES+1];

  assign adv        = !result_valid || result_ready;
  assign item_ready = adv && !cfg.busy;

  vcm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vcm_front u_front (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .v_in  (item_valid && item_ready),
    .item  (item),
    .cfg   (cfg),
    .v_out (dv[0]),
    .ds    (dd[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vcm_div_step u_step (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .v_in  (dv[g]),
      .d_in  (dd[g]),
      .sx    (cfg.sx),
      .sy    (cfg.sy),
      .v_out (dv[g+1]),
      .d_out (dd[g+1])
    );
  end

  vcm_back u_back (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .v_in  (dv[DIV_STAGES]),
    .d     (dd[DIV_STAGES]),
    .cfg   (cfg),
    .v_out (result_valid),
    .res   (result)
  );

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !item_ready)
    else $error("word taken while result stalled");

  a_cfg_write_blocks: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !item_ready)
    else $error("word taken during scale recompute");

  a_inside_needs_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !result.inside_res || result.valid_res)
    else $error("inside flag on invalid result");
`endif

endmodule
